@@ hw/rtl/first_spike_winner_decoder_macros.svh @@
// ---------------------------------------------------------------------------
// First-spike winner decoder: assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ---------------------------------------------------------------------------
`ifndef FIRST_SPIKE_WINNER_DECODER_MACROS_SVH
`define FIRST_SPIKE_WINNER_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define FSWD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define FSWD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/fswd_pkg.sv @@
// ---------------------------------------------------------------------------
// fswd_pkg
// Types, widths and codes shared by the first-spike winner decoder.
// ---------------------------------------------------------------------------
package fswd_pkg;

	localparam int NUM_SLOTS    = 16;
	localparam int MAX_TIES     = 16;
	localparam int TIME_BITS    = 32;
	localparam int SLOT_W       = 4;
	localparam int SLOTS_CFG_W  = 5;
	localparam int ID_W         = 31;
	localparam int WINDOW_W     = 31;
	localparam int RND_W        = 16;
	localparam int KIND_W       = 3;
	localparam int CFG_DATA_W   = 31;

	localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SPIKE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FORCE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd4;

	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_SLOTS  = 1'b1;

	localparam logic signed [TIME_BITS-1:0] TIME_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};

	typedef struct packed {
		logic [KIND_W-1:0]           kind;
		logic [ID_W-1:0]             nrn_id;
		logic signed [TIME_BITS-1:0] time_ticks;
		logic [RND_W-1:0]            random_word;
		logic [SLOT_W-1:0]           slot_index;
	} request_t;

	typedef struct packed {
		logic                        winner_valid;
		logic [SLOT_W-1:0]           winner_slot;
		logic signed [TIME_BITS-1:0] winner_time;
		logic                        window_expired;
	} result_t;

endpackage

@@ hw/rtl/first_spike_winner_decoder.sv @@
// ---------------------------------------------------------------------------
// first_spike_winner_decoder
// Picks the first output neuron to fire inside a decision window.
// ---------------------------------------------------------------------------
// Raise start with a request while busy is low; one result follows for every
// request, shown for a single cycle with done high, and it cannot be held
// off, so the receiver must take it then. A plain request passes through
// match, execute and reply before the block returns to idle. A request that
// decides the winner adds a read of the tie-list memory and, when more than
// one slot is tied, a bit-serial remainder of the random word by the tie
// count before that read. The id search compares all slots at once; the tie
// list lives in a synchronous memory with a registered read. No clearing pass
// runs after reset.
// ---------------------------------------------------------------------------
`include "first_spike_winner_decoder_macros.svh"

module first_spike_winner_decoder #(
	parameter int MAX_TIES = fswd_pkg::MAX_TIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  fswd_pkg::request_t                request,
	output logic                              done,
	output fswd_pkg::result_t                 result,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_index,
	input  logic [fswd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW  = $clog2(MAX_TIES + 1);
	localparam int TAW = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;
	localparam int DCW = $clog2(fswd_pkg::RND_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_EXEC,
		S_DIV,
		S_RD,
		S_PICK,
		S_REPLY
	} state_t;

	state_t state_q;

	fswd_pkg::request_t item_q;

	logic [fswd_pkg::WINDOW_W-1:0]        window_q;
	logic [fswd_pkg::SLOTS_CFG_W-1:0]     slots_q;
	logic [CW-1:0]                        tie_count_q;
	logic signed [fswd_pkg::TIME_BITS-1:0] earliest_q;
	logic signed [fswd_pkg::TIME_BITS-1:0] start_time_q;
	logic                                 decided_q;
	logic [fswd_pkg::SLOT_W-1:0]          chosen_slot_q;
	logic signed [fswd_pkg::TIME_BITS-1:0] chosen_time_q;
	logic                                 expired_q;

	logic [CW-1:0]                        rem_q;
	logic [fswd_pkg::RND_W-1:0]           dvd_q;
	logic [DCW-1:0]                       div_cnt_q;

	logic [fswd_pkg::ID_W-1:0]            id_table [fswd_pkg::NUM_SLOTS];
	logic [fswd_pkg::SLOT_W-1:0]          tie_mem [MAX_TIES];
	logic [fswd_pkg::SLOT_W-1:0]          tie_rd_q;

	// match stage results
	logic                                 found_s1;
	logic [fswd_pkg::SLOT_W-1:0]          idx_s1;
	logic                                 win_gt_s1;
	logic                                 win_ge_s1;
	logic                                 t_lt_s1;
	logic                                 t_eq_s1;

	logic                                 found;
	logic [fswd_pkg::SLOT_W-1:0]          idx;
	logic signed [fswd_pkg::TIME_BITS:0]  diff;
	logic signed [fswd_pkg::TIME_BITS:0]  window_ext;

	logic                                 restart;
	logic                                 append;
	logic                                 decide_go;
	logic                                 set_exp;
	logic                                 tie_we;
	logic [TAW-1:0]                       tie_waddr;
	logic [CW:0]                          trial;
	logic                                 accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = (state_q == S_REPLY);

	assign result.winner_valid   = decided_q;
	assign result.winner_slot    = decided_q ? chosen_slot_q : '0;
	assign result.winner_time    = decided_q ? chosen_time_q : '0;
	assign result.window_expired = expired_q;

	// Lowest slot in use that holds the requested id
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int j = fswd_pkg::NUM_SLOTS - 1; j >= 0; j--) begin
			if ((fswd_pkg::SLOTS_CFG_W'(j) < slots_q) && (id_table[j] == item_q.nrn_id)) begin
				found = 1'b1;
				idx   = fswd_pkg::SLOT_W'(j);
			end
		end
	end

	// Exact time difference, one bit wider so it cannot wrap
	assign diff = $signed({item_q.time_ticks[fswd_pkg::TIME_BITS-1], item_q.time_ticks})
		- $signed({start_time_q[fswd_pkg::TIME_BITS-1], start_time_q});
	assign window_ext = $signed({{(fswd_pkg::TIME_BITS + 1 - fswd_pkg::WINDOW_W){1'b0}}, window_q});

	always_ff @(posedge clk) begin
		if (state_q == S_MATCH) begin
			found_s1  <= found;
			idx_s1    <= idx;
			win_gt_s1 <= (diff > window_ext);
			win_ge_s1 <= (diff >= window_ext);
			t_lt_s1   <= (item_q.time_ticks < earliest_q);
			t_eq_s1   <= (item_q.time_ticks == earliest_q);
		end
	end

	// Request decode in the execute cycle
	always_comb begin
		restart   = 1'b0;
		append    = 1'b0;
		decide_go = 1'b0;
		set_exp   = 1'b0;
		case (item_q.kind)
			fswd_pkg::KIND_SPIKE: begin
				if (!expired_q && !decided_q) begin
					if (win_gt_s1) begin
						set_exp = 1'b1;
					end else if (found_s1) begin
						if ((tie_count_q == '0) || t_lt_s1) begin
							restart = 1'b1;
						end else if (t_eq_s1) begin
							// drop ties beyond the list depth
							append = (tie_count_q < CW'(MAX_TIES));
						end else begin
							decide_go = 1'b1;
						end
					end
				end
			end
			fswd_pkg::KIND_TIMEOUT: begin
				if (!decided_q) begin
					if ((tie_count_q != '0) && !t_lt_s1) begin
						decide_go = 1'b1;
					end else if (win_ge_s1) begin
						set_exp = 1'b1;
					end
				end
			end
			fswd_pkg::KIND_FORCE: begin
				decide_go = !decided_q && (tie_count_q != '0);
			end
			default: begin
			end
		endcase
	end

	assign tie_we    = (state_q == S_EXEC) && (restart || append);
	assign tie_waddr = restart ? '0 : tie_count_q[TAW-1:0];
	assign trial     = {rem_q, dvd_q[fswd_pkg::RND_W-1]};

	// Tie list memory, registered read
	always_ff @(posedge clk) begin
		if (tie_we) begin
			tie_mem[tie_waddr] <= idx_s1;
		end
		if (state_q == S_RD) begin
			tie_rd_q <= tie_mem[rem_q[TAW-1:0]];
		end
	end

	// Id table and request hold
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= request;
		end
		if ((state_q == S_EXEC) && (item_q.kind == fswd_pkg::KIND_LOAD)
			&& ({1'b0, item_q.slot_index} < (fswd_pkg::SLOT_W + 1)'(fswd_pkg::NUM_SLOTS))) begin
			id_table[item_q.slot_index] <= item_q.nrn_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			window_q      <= '0;
			slots_q       <= '0;
			tie_count_q   <= '0;
			earliest_q    <= fswd_pkg::TIME_MAX;
			start_time_q  <= '0;
			decided_q     <= 1'b0;
			chosen_slot_q <= '0;
			chosen_time_q <= '0;
			expired_q     <= 1'b0;
			rem_q         <= '0;
			dvd_q         <= '0;
			div_cnt_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					fswd_pkg::CFG_WINDOW: window_q <= cfg_data[fswd_pkg::WINDOW_W-1:0];
					fswd_pkg::CFG_SLOTS:  slots_q  <= cfg_data[fswd_pkg::SLOTS_CFG_W-1:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_REPLY;
					if (item_q.kind == fswd_pkg::KIND_START) begin
						decided_q     <= 1'b0;
						expired_q     <= 1'b0;
						tie_count_q   <= '0;
						chosen_slot_q <= '0;
						chosen_time_q <= '0;
						start_time_q  <= item_q.time_ticks;
						earliest_q    <= fswd_pkg::TIME_MAX;
					end
					if (set_exp) begin
						expired_q <= 1'b1;
					end
					if (restart) begin
						earliest_q  <= item_q.time_ticks;
						tie_count_q <= CW'(1);
					end
					if (append) begin
						tie_count_q <= tie_count_q + CW'(1);
					end
					if (decide_go) begin
						rem_q     <= '0;
						dvd_q     <= item_q.random_word;
						div_cnt_q <= DCW'(fswd_pkg::RND_W - 1);
						// a single tie needs no remainder
						state_q   <= (tie_count_q == CW'(1)) ? S_RD : S_DIV;
					end
				end
				S_DIV: begin
					if (trial >= {1'b0, tie_count_q}) begin
						rem_q <= CW'(trial - {1'b0, tie_count_q});
					end else begin
						rem_q <= trial[CW-1:0];
					end
					dvd_q     <= {dvd_q[fswd_pkg::RND_W-2:0], 1'b0};
					div_cnt_q <= div_cnt_q - DCW'(1);
					if (div_cnt_q == '0) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					chosen_slot_q <= tie_rd_q;
					chosen_time_q <= earliest_q;
					decided_q     <= 1'b1;
					tie_count_q   <= '0;
					state_q       <= S_REPLY;
				end
				S_REPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FSWD_ASSERT_IMP(a_count_bound, 1'b1, tie_count_q <= CW'(MAX_TIES), "tie count beyond list depth")
	`FSWD_ASSERT_IMP(a_decided_empty, decided_q, tie_count_q == '0, "tie list kept after decision")
	`FSWD_ASSERT_IMP(a_pick_in_range, state_q == S_RD, rem_q < tie_count_q, "tie pick out of range")
	`FSWD_ASSERT_NXT(a_reply_frees, done, !busy, "block still busy after result")

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// First-spike winner decoder testbench
// Loads the id table and then drives windows, spikes, timeout checks, forced
// results and loads through the start/busy port. A predictor in the bench works
// out the status after each accepted request, and every done strobe is checked
// field by field against the oldest prediction. Directed cases come first,
// then random decision rounds with noise under several register settings and
// sender idling patterns.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [fswd_pkg::KIND_W-1:0] KIND_UNUSED_A = 3'd5;
	localparam logic [fswd_pkg::KIND_W-1:0] KIND_UNUSED_B = 3'd6;
	localparam logic [fswd_pkg::KIND_W-1:0] KIND_UNUSED_C = 3'd7;
	localparam longint TIME_HI = longint'(fswd_pkg::TIME_MAX);
	localparam longint TIME_LO = -TIME_HI - 1;
	localparam logic [fswd_pkg::WINDOW_W-1:0] WINDOW_MAX = {fswd_pkg::WINDOW_W{1'b1}};
	localparam logic [fswd_pkg::ID_W-1:0] ID_MAX = {fswd_pkg::ID_W{1'b1}};
	localparam logic [fswd_pkg::RND_W-1:0] RND_MAX = {fswd_pkg::RND_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	fswd_pkg::request_t request;
	logic done;
	fswd_pkg::result_t result;
	logic cfg_wr_en;
	logic cfg_index;
	logic [fswd_pkg::CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic [fswd_pkg::ID_W-1:0] id_slots [fswd_pkg::NUM_SLOTS];
	logic [fswd_pkg::SLOT_W-1:0] tied_slots [fswd_pkg::MAX_TIES];
	int tie_total;
	longint first_time;
	longint window_open_time;
	logic have_winner;
	logic [fswd_pkg::SLOT_W-1:0] winner_idx;
	longint winner_at;
	logic expired;
	longint window_len;
	int active_slots;

	fswd_pkg::result_t pending_results [$];
	int mismatches = 0;
	int requests_sent = 0;
	int idle_pct = 0;

	first_spike_winner_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void pick_winner(logic [fswd_pkg::RND_W-1:0] rnd);
		if (!have_winner && tie_total != 0) begin
			winner_idx = tied_slots[int'(rnd) % tie_total];
			winner_at = first_time;
			have_winner = 1'b1;
			tie_total = 0;
		end
	endfunction

	function automatic fswd_pkg::result_t predict_decision(fswd_pkg::request_t r);
		fswd_pkg::result_t res;
		longint t;
		int n;
		int idx;
		logic found;
		t = longint'(r.time_ticks);
		n = (active_slots > fswd_pkg::NUM_SLOTS) ? fswd_pkg::NUM_SLOTS : active_slots;
		idx = 0;
		found = 1'b0;
		case (r.kind)
			fswd_pkg::KIND_START: begin
				have_winner = 1'b0;
				expired = 1'b0;
				tie_total = 0;
				winner_idx = '0;
				winner_at = 0;
				window_open_time = t;
				first_time = TIME_HI;
			end
			fswd_pkg::KIND_SPIKE: begin
				if (!expired && !have_winner) begin
					if (t - window_open_time > window_len) begin
						expired = 1'b1;
					end else begin
						// lowest matching slot wins the search
						for (int j = 0; j < n; j++) begin
							if (!found && id_slots[j] == r.nrn_id) begin
								idx = j;
								found = 1'b1;
							end
						end
						if (found) begin
							if (tie_total == 0 || t < first_time) begin
								first_time = t;
								tied_slots[0] = idx[fswd_pkg::SLOT_W-1:0];
								tie_total = 1;
							end else if (t == first_time) begin
								if (tie_total < fswd_pkg::MAX_TIES) begin
									tied_slots[tie_total] = idx[fswd_pkg::SLOT_W-1:0];
									tie_total++;
								end
							end else begin
								pick_winner(r.random_word);
							end
						end
					end
				end
			end
			fswd_pkg::KIND_TIMEOUT: begin
				if (!have_winner) begin
					if (tie_total != 0 && t >= first_time)
						pick_winner(r.random_word);
					else if (t - window_open_time >= window_len)
						expired = 1'b1;
				end
			end
			fswd_pkg::KIND_FORCE: pick_winner(r.random_word);
			fswd_pkg::KIND_LOAD: id_slots[r.slot_index] = r.nrn_id;
			default: ;
		endcase
		res.winner_valid = have_winner;
		res.winner_slot = have_winner ? winner_idx : '0;
		res.winner_time = have_winner ? winner_at[fswd_pkg::TIME_BITS-1:0] : '0;
		res.window_expired = expired;
		return res;
	endfunction

	function automatic logic signed [fswd_pkg::TIME_BITS-1:0] clamp_time(longint v);
		if (v > TIME_HI)
			return fswd_pkg::TIME_MAX;
		if (v < TIME_LO)
			return TIME_LO[fswd_pkg::TIME_BITS-1:0];
		return v[fswd_pkg::TIME_BITS-1:0];
	endfunction

	// an id held in no slot at all
	function automatic logic [fswd_pkg::ID_W-1:0] absent_id();
		logic [fswd_pkg::ID_W-1:0] v;
		logic hit;
		do begin
			v = fswd_pkg::ID_W'($urandom());
			hit = 1'b0;
			for (int j = 0; j < fswd_pkg::NUM_SLOTS; j++)
				if (id_slots[j] == v)
					hit = 1'b1;
		end while (hit);
		return v;
	endfunction

	task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
	endtask

	always @(posedge clk) begin : result_check
		fswd_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_field("unexpected result", '0, 64'(result));
			end else begin
				want = pending_results.pop_front();
				if (result.winner_valid !== want.winner_valid)
					report_field("winner_valid", 64'(want.winner_valid),
						64'(result.winner_valid));
				if (result.winner_slot !== want.winner_slot)
					report_field("winner_slot", 64'(want.winner_slot),
						64'(result.winner_slot));
				if (result.winner_time !== want.winner_time)
					report_field("winner_time", 64'(want.winner_time),
						64'(result.winner_time));
				if (result.window_expired !== want.window_expired)
					report_field("window_expired", 64'(want.window_expired),
						64'(result.window_expired));
			end
		end
	end

	// Send one request; returns at the edge that accepts it, start left high.
	task automatic issue(logic [fswd_pkg::KIND_W-1:0] kind, logic [fswd_pkg::ID_W-1:0] nid,
		longint t, logic [fswd_pkg::RND_W-1:0] rnd, logic [fswd_pkg::SLOT_W-1:0] slot);
		fswd_pkg::request_t r;
		r.kind = kind;
		r.nrn_id = nid;
		r.time_ticks = clamp_time(t);
		r.random_word = rnd;
		r.slot_index = slot;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		pending_results.insert(pending_results.size(), predict_decision(r));
		requests_sent++;
	endtask

	task automatic issue_noise();
		issue(fswd_pkg::KIND_W'($urandom_range(0, 7)), fswd_pkg::ID_W'($urandom()),
			longint'(int'($urandom())), fswd_pkg::RND_W'($urandom_range(0, 65535)),
			fswd_pkg::SLOT_W'($urandom_range(0, fswd_pkg::NUM_SLOTS - 1)));
	endtask

	// Hold off until every result is in and the block is idle, then write both
	// registers, the window first and the slot count after it.
	task automatic set_registers(logic [fswd_pkg::WINDOW_W-1:0] window,
		logic [fswd_pkg::SLOTS_CFG_W-1:0] slots);
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy);
		cfg_wr_en <= 1'b1;
		cfg_index <= fswd_pkg::CFG_WINDOW;
		cfg_data <= window;
		@(posedge clk);
		cfg_index <= fswd_pkg::CFG_SLOTS;
		cfg_data <= fswd_pkg::CFG_DATA_W'(slots);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_len = longint'(window);
		active_slots = int'(slots);
	endtask

	task automatic test_id_table_load();
		for (int j = 0; j < fswd_pkg::NUM_SLOTS; j++)
			issue(fswd_pkg::KIND_LOAD, fswd_pkg::ID_W'($urandom()), longint'($urandom()),
				fswd_pkg::RND_W'($urandom_range(0, 65535)), fswd_pkg::SLOT_W'(j));
		issue(fswd_pkg::KIND_LOAD, '0, 0, '0, 4'd0);
		issue(fswd_pkg::KIND_LOAD, ID_MAX, 0, '0, 4'd1);
		// slot 5 shadows slot 3: the lower slot must win
		issue(fswd_pkg::KIND_LOAD, id_slots[3], 0, '0, 4'd5);
	endtask

	task automatic test_first_spike_and_ties();
		set_registers(20, fswd_pkg::SLOTS_CFG_W'(fswd_pkg::NUM_SLOTS));
		issue(fswd_pkg::KIND_START, '0, 1000, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[1], 1005, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, absent_id(), 1004, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[0], 1005, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[5], 1005, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[7], 1003, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[8], 1003, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[9], 1004, RND_MAX, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[2], 1001, '0, '0);
		issue(fswd_pkg::KIND_TIMEOUT, '0, 2000, '0, '0);
		issue(KIND_UNUSED_A, id_slots[2], 1000, '0, 4'd3);
		issue(KIND_UNUSED_B, ID_MAX, TIME_HI, RND_MAX, 4'd15);
		issue(KIND_UNUSED_C, '0, TIME_LO, '0, '0);
	endtask

	task automatic test_window_edges();
		issue(fswd_pkg::KIND_START, '0, TIME_LO, '0, '0);
		issue(fswd_pkg::KIND_TIMEOUT, '0, TIME_LO + 19, '0, '0);
		issue(fswd_pkg::KIND_FORCE, '0, 0, RND_MAX, '0);
		issue(fswd_pkg::KIND_TIMEOUT, '0, TIME_LO + 20, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[4], TIME_LO + 1, '0, '0);
		issue(fswd_pkg::KIND_START, '0, 0, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[6], 20, '0, '0);
		issue(fswd_pkg::KIND_TIMEOUT, '0, 19, '0, '0);
		issue(fswd_pkg::KIND_TIMEOUT, '0, 30, 16'd7, '0);
		issue(fswd_pkg::KIND_START, '0, 0, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[10], 21, '0, '0);
		// expired first, then decided by a forced result
		issue(fswd_pkg::KIND_START, '0, 5, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[11], 10, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[12], 100, '0, '0);
		issue(fswd_pkg::KIND_FORCE, '0, 0, '0, '0);
	endtask

	task automatic test_register_extremes();
		set_registers(WINDOW_MAX, 5'd31);
		issue(fswd_pkg::KIND_START, '0, TIME_LO, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[13], TIME_HI, '0, '0);
		issue(fswd_pkg::KIND_START, '0, TIME_LO, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[15], -1, '0, '0);
		issue(fswd_pkg::KIND_TIMEOUT, '0, TIME_HI, RND_MAX, '0);
		set_registers('0, '0);
		issue(fswd_pkg::KIND_START, '0, 7, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[0], 7, '0, '0);
		issue(fswd_pkg::KIND_TIMEOUT, '0, 7, '0, '0);
		set_registers('0, fswd_pkg::SLOTS_CFG_W'(fswd_pkg::NUM_SLOTS));
		issue(fswd_pkg::KIND_START, '0, 7, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[14], 7, '0, '0);
		issue(fswd_pkg::KIND_SPIKE, id_slots[2], 8, '0, '0);
		issue(fswd_pkg::KIND_FORCE, '0, 0, 16'd3, '0);
	endtask

	// One window: a start, a run of spikes clustered round one time, and in most rounds a close.
	task automatic run_round();
		longint t0;
		longint base;
		longint t;
		int spikes;
		int roll;
		logic [fswd_pkg::ID_W-1:0] nid;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			t0 = TIME_LO;
		else if (roll == 1)
			t0 = TIME_HI - longint'($urandom_range(0, 50));
		else
			t0 = longint'(int'($urandom()));
		issue(fswd_pkg::KIND_START, fswd_pkg::ID_W'($urandom()), t0,
			fswd_pkg::RND_W'($urandom_range(0, 65535)), fswd_pkg::SLOT_W'($urandom_range(0, 15)));
		if ($urandom_range(0, 4) != 0)
			base = t0 + ((window_len < 30) ? longint'($urandom_range(0, int'(window_len)))
				: longint'($urandom_range(0, 30)));
		else
			base = t0 + longint'($urandom_range(0, 60));
		spikes = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(1, 7);
		for (int k = 0; k < spikes; k++) begin
			if ($urandom_range(0, 9) == 0)
				issue_noise();
			nid = ($urandom_range(0, 99) < 85)
				? id_slots[$urandom_range(0, fswd_pkg::NUM_SLOTS - 1)]
				: fswd_pkg::ID_W'($urandom());
			roll = (spikes == 20) ? 0 : $urandom_range(0, 9);
			if (roll <= 5) begin
				t = base;
			end else if (roll == 6) begin
				base = base - 1;
				t = base;
			end else if (roll <= 8) begin
				t = base + longint'($urandom_range(1, 3));
			end else begin
				t = t0 + window_len + longint'($urandom_range(0, 2));
			end
			issue(fswd_pkg::KIND_SPIKE, nid, t, fswd_pkg::RND_W'($urandom_range(0, 65535)),
				fswd_pkg::SLOT_W'($urandom_range(0, 15)));
		end
		case ($urandom_range(0, 3))
			0: issue(fswd_pkg::KIND_TIMEOUT, fswd_pkg::ID_W'($urandom()),
				base + longint'($urandom_range(0, 2)) - 1,
				fswd_pkg::RND_W'($urandom_range(0, 65535)),
				fswd_pkg::SLOT_W'($urandom_range(0, 15)));
			1: issue(fswd_pkg::KIND_TIMEOUT, fswd_pkg::ID_W'($urandom()),
				t0 + window_len + longint'($urandom_range(0, 2)) - 1,
				fswd_pkg::RND_W'($urandom_range(0, 65535)),
				fswd_pkg::SLOT_W'($urandom_range(0, 15)));
			2: issue(fswd_pkg::KIND_FORCE, fswd_pkg::ID_W'($urandom()),
				longint'(int'($urandom())), fswd_pkg::RND_W'($urandom_range(0, 65535)),
				fswd_pkg::SLOT_W'($urandom_range(0, 15)));
			default: ;
		endcase
	endtask

	task automatic test_random_rounds();
		int idle_plan [4] = '{0, 64, 0, 15};
		logic [fswd_pkg::WINDOW_W-1:0] window;
		logic [fswd_pkg::SLOTS_CFG_W-1:0] slots;
		int target;
		for (int phase = 0; phase < 4; phase++) begin
			for (int step = 0; step < 4; step++) begin
				case ((phase + step) % 5)
					0: window = '0;
					1: window = fswd_pkg::WINDOW_W'($urandom_range(1, 8));
					2: window = fswd_pkg::WINDOW_W'($urandom_range(10, 60));
					3: window = fswd_pkg::WINDOW_W'($urandom());
					default: window = WINDOW_MAX;
				endcase
				case (step)
					0: slots = fswd_pkg::SLOTS_CFG_W'(fswd_pkg::NUM_SLOTS);
					1: slots = (phase == 1) ? '0
						: fswd_pkg::SLOTS_CFG_W'($urandom_range(1, fswd_pkg::NUM_SLOTS - 1));
					2: slots = fswd_pkg::SLOTS_CFG_W'($urandom_range(fswd_pkg::NUM_SLOTS + 1, 31));
					default: slots = fswd_pkg::SLOTS_CFG_W'($urandom_range(0, fswd_pkg::NUM_SLOTS));
				endcase
				set_registers(window, slots);
				idle_pct = idle_plan[phase];
				// refresh two slots, the second with an id copied from a random slot
				issue(fswd_pkg::KIND_LOAD, fswd_pkg::ID_W'($urandom()), longint'(int'($urandom())),
					fswd_pkg::RND_W'($urandom_range(0, 65535)),
					fswd_pkg::SLOT_W'($urandom_range(0, fswd_pkg::NUM_SLOTS - 1)));
				issue(fswd_pkg::KIND_LOAD, id_slots[$urandom_range(0, fswd_pkg::NUM_SLOTS - 1)],
					0, '0, fswd_pkg::SLOT_W'($urandom_range(0, fswd_pkg::NUM_SLOTS - 1)));
				target = requests_sent + 36;
				while (requests_sent < target)
					run_round();
			end
		end
		idle_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_wr_en = 1'b0;
		cfg_index = fswd_pkg::CFG_WINDOW;
		cfg_data = '0;
		for (int j = 0; j < fswd_pkg::NUM_SLOTS; j++)
			id_slots[j] = '0;
		for (int j = 0; j < fswd_pkg::MAX_TIES; j++)
			tied_slots[j] = '0;
		tie_total = 0;
		first_time = TIME_HI;
		window_open_time = 0;
		have_winner = 1'b0;
		winner_idx = '0;
		winner_at = 0;
		expired = 1'b0;
		window_len = 0;
		active_slots = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_id_table_load();
		test_first_spike_and_ties();
		test_window_edges();
		test_register_extremes();
		test_random_rounds();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
